FILE: sv/clip_edge_intersect_core_defines.svh
// ----------------------------------------------------------------------------
// clip_edge_intersect_core_defines
// Assertion macros for the edge clip core; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef CLIP_EDGE_INTERSECT_CORE_DEFINES_SVH
`define CLIP_EDGE_INTERSECT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define CEI_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("cei: assertion failed");
`define CEI_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("cei: forbidden condition seen");
`else
`define CEI_ASSERT(label, prop)
`define CEI_NEVER(label, cond)
`endif

`endif

FILE: sv/cei_pkg.sv
// ----------------------------------------------------------------------------
// cei_pkg
// Shared types and constants of the edge clip intersection core.
// ----------------------------------------------------------------------------
package cei_pkg;

	localparam int POS_WIDTH   = 16;
	localparam int TEX_WIDTH   = 24;
	localparam int T_FRAC_BITS = 16;

	localparam logic [1:0] REG_LEFT   = 2'd0;
	localparam logic [1:0] REG_RIGHT  = 2'd1;
	localparam logic [1:0] REG_TOP    = 2'd2;
	localparam logic [1:0] REG_BOTTOM = 2'd3;

	typedef enum logic [1:0] {
		MODE_TOP    = 2'd0,
		MODE_BOTTOM = 2'd1,
		MODE_LEFT   = 2'd2,
		MODE_RIGHT  = 2'd3
	} mode_t;

	// control that travels with each beat
	typedef struct packed {
		logic valid;
		logic go;        // edge crosses the boundary strictly inside
		logic across_y;  // boundary is horizontal
	} ctl_t;

endpackage

FILE: sv/clip_edge_intersect_core.sv
// ----------------------------------------------------------------------------
// clip_edge_intersect_core
// Intersects a textured edge with one axis-aligned clip boundary.
//
//   channel   handshake             payload
//   input     start / busy          mode, start_*, end_*
//   result    done (strobe)         hit, out_x, out_y, out_u, out_v
//   config    cfg_we                cfg_index, cfg_data
//
// One edge per cycle. The pipeline has two setup stages, one divider stage per
// bit of t, the multiply stage and the output register.
// busy stays low; the pipeline never stalls since results cannot be held off.
// Reset clears the beat valids and loads the boundary reset values.
// ----------------------------------------------------------------------------
`include "clip_edge_intersect_core_defines.svh"

module clip_edge_intersect_core #(
	parameter int POS_WIDTH   = cei_pkg::POS_WIDTH,
	parameter int TEX_WIDTH   = cei_pkg::TEX_WIDTH,
	parameter int T_FRAC_BITS = cei_pkg::T_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           mode,
	input  logic [POS_WIDTH-1:0] start_x,
	input  logic [POS_WIDTH-1:0] start_y,
	input  logic [TEX_WIDTH-1:0] start_u,
	input  logic [TEX_WIDTH-1:0] start_v,
	input  logic [POS_WIDTH-1:0] end_x,
	input  logic [POS_WIDTH-1:0] end_y,
	input  logic [TEX_WIDTH-1:0] end_u,
	input  logic [TEX_WIDTH-1:0] end_v,
	output logic                 done,
	output logic                 hit,
	output logic [POS_WIDTH-1:0] out_x,
	output logic [POS_WIDTH-1:0] out_y,
	output logic [TEX_WIDTH-1:0] out_u,
	output logic [TEX_WIDTH-1:0] out_v,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [POS_WIDTH-1:0] cfg_data
);

	localparam int PW      = POS_WIDTH;
	localparam int TW      = TEX_WIDTH;
	localparam int DATA_W  = 3 * PW + 2 + 2 * (2 * TW + 2);
	localparam int LATENCY = T_FRAC_BITS + 4;

	logic [PW-1:0] left_q, right_q, top_q, bottom_q;

	cei_pkg::ctl_t ctl_su;
	logic [PW:0]   anum, aden, mag_o;
	logic [PW-1:0] bound, so;
	logic          neg_o, neg_u, neg_v;
	logic [TW-1:0] su, sv;
	logic [TW:0]   mag_u, mag_v;

	cei_pkg::ctl_t       ctl_dv;
	logic [T_FRAC_BITS-1:0] t_dv;
	logic [DATA_W-1:0]   data_su, data_dv;

	logic [PW-1:0] bound_dv, so_dv;
	logic          neg_o_dv, neg_u_dv, neg_v_dv;
	logic [PW:0]   mag_o_dv;
	logic [TW-1:0] su_dv, sv_dv;
	logic [TW:0]   mag_u_dv, mag_v_dv;

	cei_pkg::ctl_t ctl_s3;
	logic [PW-1:0] bound_s3;
	logic [PW-1:0] res_o;
	logic [TW-1:0] res_u, res_v;

	logic          done_q, hit_q;
	logic [PW-1:0] out_x_q, out_y_q;
	logic [TW-1:0] out_u_q, out_v_q;

	// boundary registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			right_q  <= {1'b0, {(PW-1){1'b1}}};
			top_q    <= '0;
			bottom_q <= {1'b0, {(PW-1){1'b1}}};
		end else if (cfg_we) begin
			unique case (cfg_index)
				cei_pkg::REG_LEFT:   left_q   <= cfg_data;
				cei_pkg::REG_RIGHT:  right_q  <= cfg_data;
				cei_pkg::REG_TOP:    top_q    <= cfg_data;
				cei_pkg::REG_BOTTOM: bottom_q <= cfg_data;
				default:             left_q   <= left_q;
			endcase
		end
	end

	assign busy = 1'b0;

	cei_setup #(
		.POS_WIDTH (PW),
		.TEX_WIDTH (TW)
	) u_setup (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (start),
		.mode        (mode),
		.start_x     (start_x),
		.start_y     (start_y),
		.start_u     (start_u),
		.start_v     (start_v),
		.end_x       (end_x),
		.end_y       (end_y),
		.end_u       (end_u),
		.end_v       (end_v),
		.left_edge   (left_q),
		.right_edge  (right_q),
		.top_edge    (top_q),
		.bottom_edge (bottom_q),
		.ctl         (ctl_su),
		.anum        (anum),
		.aden        (aden),
		.bound       (bound),
		.so          (so),
		.neg_o       (neg_o),
		.mag_o       (mag_o),
		.su          (su),
		.neg_u       (neg_u),
		.mag_u       (mag_u),
		.sv          (sv),
		.neg_v       (neg_v),
		.mag_v       (mag_v)
	);

	assign data_su = {bound, so, neg_o, mag_o, su, neg_u, mag_u, sv, neg_v, mag_v};

	cei_div #(
		.NUM_W  (PW + 1),
		.QW     (T_FRAC_BITS),
		.DATA_W (DATA_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ctl   (ctl_su),
		.in_num   (anum),
		.in_den   (aden),
		.in_data  (data_su),
		.out_ctl  (ctl_dv),
		.out_quo  (t_dv),
		.out_data (data_dv)
	);

	assign {bound_dv, so_dv, neg_o_dv, mag_o_dv, su_dv, neg_u_dv, mag_u_dv,
		sv_dv, neg_v_dv, mag_v_dv} = data_dv;

	cei_lerp #(.W(PW), .TF(T_FRAC_BITS)) u_lerp_o (
		.clk (clk),
		.s   (so_dv),
		.neg (neg_o_dv),
		.mag (mag_o_dv),
		.t   (t_dv),
		.res (res_o)
	);

	cei_lerp #(.W(TW), .TF(T_FRAC_BITS)) u_lerp_u (
		.clk (clk),
		.s   (su_dv),
		.neg (neg_u_dv),
		.mag (mag_u_dv),
		.t   (t_dv),
		.res (res_u)
	);

	cei_lerp #(.W(TW), .TF(T_FRAC_BITS)) u_lerp_v (
		.clk (clk),
		.s   (sv_dv),
		.neg (neg_v_dv),
		.mag (mag_v_dv),
		.t   (t_dv),
		.res (res_v)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3 <= ctl_dv;
		end
	end

	always_ff @(posedge clk) begin
		bound_s3 <= bound_dv;
	end

	// output register; a miss returns all zeros
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			done_q <= ctl_s3.valid;
			hit_q  <= ctl_s3.valid & ctl_s3.go;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s3.go) begin
			out_x_q <= ctl_s3.across_y ? res_o : bound_s3;
			out_y_q <= ctl_s3.across_y ? bound_s3 : res_o;
			out_u_q <= res_u;
			out_v_q <= res_v;
		end else begin
			out_x_q <= '0;
			out_y_q <= '0;
			out_u_q <= '0;
			out_v_q <= '0;
		end
	end

	assign done  = done_q;
	assign hit   = hit_q;
	assign out_x = out_x_q;
	assign out_y = out_y_q;
	assign out_u = out_u_q;
	assign out_v = out_v_q;

	`CEI_ASSERT(a_latency, (start && !busy) |-> ##LATENCY done)
	`CEI_ASSERT(a_no_phantom, done |-> $past(start, LATENCY))
	`CEI_NEVER(a_hit_without_done, hit && !done)
	`CEI_NEVER(a_miss_zero, done && !hit && ({out_x, out_y, out_u, out_v} != '0))

endmodule

FILE: sv/cei_setup.sv
// ----------------------------------------------------------------------------
// cei_setup
// Two front stages: boundary select and differences, then magnitudes and
// the crossing test.
// ----------------------------------------------------------------------------
module cei_setup #(
	parameter int POS_WIDTH = cei_pkg::POS_WIDTH,
	parameter int TEX_WIDTH = cei_pkg::TEX_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [1:0]           mode,
	input  logic [POS_WIDTH-1:0] start_x,
	input  logic [POS_WIDTH-1:0] start_y,
	input  logic [TEX_WIDTH-1:0] start_u,
	input  logic [TEX_WIDTH-1:0] start_v,
	input  logic [POS_WIDTH-1:0] end_x,
	input  logic [POS_WIDTH-1:0] end_y,
	input  logic [TEX_WIDTH-1:0] end_u,
	input  logic [TEX_WIDTH-1:0] end_v,
	input  logic [POS_WIDTH-1:0] left_edge,
	input  logic [POS_WIDTH-1:0] right_edge,
	input  logic [POS_WIDTH-1:0] top_edge,
	input  logic [POS_WIDTH-1:0] bottom_edge,
	output cei_pkg::ctl_t        ctl,
	output logic [POS_WIDTH:0]   anum,
	output logic [POS_WIDTH:0]   aden,
	output logic [POS_WIDTH-1:0] bound,
	output logic [POS_WIDTH-1:0] so,
	output logic                 neg_o,
	output logic [POS_WIDTH:0]   mag_o,
	output logic [TEX_WIDTH-1:0] su,
	output logic                 neg_u,
	output logic [TEX_WIDTH:0]   mag_u,
	output logic [TEX_WIDTH-1:0] sv,
	output logic                 neg_v,
	output logic [TEX_WIDTH:0]   mag_v
);

	localparam int PW = POS_WIDTH;
	localparam int TW = TEX_WIDTH;

	logic          across_y;
	logic [PW-1:0] bnd;
	logic [PW-1:0] sc, ec, sother, eother;

	logic          valid_s1, across_y_s1;
	logic [PW-1:0] bound_s1, so_s1;
	logic [PW:0]   num_s1, den_s1, d_o_s1;
	logic [TW-1:0] su_s1, sv_s1;
	logic [TW:0]   d_u_s1, d_v_s1;

	logic [PW:0]   anum_c, aden_c;

	cei_pkg::ctl_t ctl_s2;
	logic [PW:0]   anum_s2, aden_s2, mag_o_s2;
	logic [PW-1:0] bound_s2, so_s2;
	logic          neg_o_s2, neg_u_s2, neg_v_s2;
	logic [TW-1:0] su_s2, sv_s2;
	logic [TW:0]   mag_u_s2, mag_v_s2;

	always_comb begin
		unique case (cei_pkg::mode_t'(mode))
			cei_pkg::MODE_TOP: begin
				bnd      = top_edge;
				across_y = 1'b1;
			end
			cei_pkg::MODE_BOTTOM: begin
				bnd      = bottom_edge;
				across_y = 1'b1;
			end
			cei_pkg::MODE_LEFT: begin
				bnd      = left_edge;
				across_y = 1'b0;
			end
			default: begin
				bnd      = right_edge;
				across_y = 1'b0;
			end
		endcase
		sc     = across_y ? start_y : start_x;
		ec     = across_y ? end_y   : end_x;
		sother = across_y ? start_x : start_y;
		eother = across_y ? end_x   : end_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		across_y_s1 <= across_y;
		bound_s1    <= bnd;
		so_s1       <= sother;
		num_s1      <= {bnd[PW-1], bnd} - {sc[PW-1], sc};
		den_s1      <= {ec[PW-1], ec} - {sc[PW-1], sc};
		d_o_s1      <= {eother[PW-1], eother} - {sother[PW-1], sother};
		su_s1       <= start_u;
		sv_s1       <= start_v;
		d_u_s1      <= {end_u[TW-1], end_u} - {start_u[TW-1], start_u};
		d_v_s1      <= {end_v[TW-1], end_v} - {start_v[TW-1], start_v};
	end

	assign anum_c = num_s1[PW] ? (~num_s1 + 1'b1) : num_s1;
	assign aden_c = den_s1[PW] ? (~den_s1 + 1'b1) : den_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2.valid    <= valid_s1;
			ctl_s2.across_y <= across_y_s1;
			ctl_s2.go       <= (den_s1 != '0) && (num_s1 != '0)
				&& (num_s1[PW] == den_s1[PW]) && (anum_c < aden_c);
		end
	end

	always_ff @(posedge clk) begin
		anum_s2  <= anum_c;
		aden_s2  <= aden_c;
		bound_s2 <= bound_s1;
		so_s2    <= so_s1;
		neg_o_s2 <= d_o_s1[PW];
		mag_o_s2 <= d_o_s1[PW] ? (~d_o_s1 + 1'b1) : d_o_s1;
		su_s2    <= su_s1;
		neg_u_s2 <= d_u_s1[TW];
		mag_u_s2 <= d_u_s1[TW] ? (~d_u_s1 + 1'b1) : d_u_s1;
		sv_s2    <= sv_s1;
		neg_v_s2 <= d_v_s1[TW];
		mag_v_s2 <= d_v_s1[TW] ? (~d_v_s1 + 1'b1) : d_v_s1;
	end

	assign ctl   = ctl_s2;
	assign anum  = anum_s2;
	assign aden  = aden_s2;
	assign bound = bound_s2;
	assign so    = so_s2;
	assign neg_o = neg_o_s2;
	assign mag_o = mag_o_s2;
	assign su    = su_s2;
	assign neg_u = neg_u_s2;
	assign mag_u = mag_u_s2;
	assign sv    = sv_s2;
	assign neg_v = neg_v_s2;
	assign mag_v = mag_v_s2;

endmodule

FILE: sv/cei_div.sv
// ----------------------------------------------------------------------------
// cei_div
// Pipelined restoring divider, one quotient bit per stage. Needs num < den;
// returns floor(num * 2^QW / den) and carries a side payload along.
// ----------------------------------------------------------------------------
module cei_div #(
	parameter int NUM_W  = cei_pkg::POS_WIDTH + 1,
	parameter int QW     = cei_pkg::T_FRAC_BITS,
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cei_pkg::ctl_t     in_ctl,
	input  logic [NUM_W-1:0]  in_num,
	input  logic [NUM_W-1:0]  in_den,
	input  logic [DATA_W-1:0] in_data,
	output cei_pkg::ctl_t     out_ctl,
	output logic [QW-1:0]     out_quo,
	output logic [DATA_W-1:0] out_data
);

	cei_pkg::ctl_t     ctl_s  [QW];
	logic [NUM_W-1:0]  rem_s  [QW];
	logic [NUM_W-1:0]  den_s  [QW];
	logic [QW-1:0]     quo_s  [QW];
	logic [DATA_W-1:0] data_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		cei_pkg::ctl_t     src_ctl;
		logic [NUM_W-1:0]  src_rem, src_den;
		logic [QW-1:0]     src_quo;
		logic [DATA_W-1:0] src_data;
		logic [NUM_W:0]    sh;
		logic [NUM_W+1:0]  diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign src_ctl  = in_ctl;
			assign src_rem  = in_num;
			assign src_den  = in_den;
			assign src_quo  = '0;
			assign src_data = in_data;
		end else begin : g_next
			assign src_ctl  = ctl_s[k-1];
			assign src_rem  = rem_s[k-1];
			assign src_den  = den_s[k-1];
			assign src_quo  = quo_s[k-1];
			assign src_data = data_s[k-1];
		end

		assign sh   = {src_rem, 1'b0};
		assign diff = {1'b0, sh} - {2'b00, src_den};
		assign ge   = ~diff[NUM_W+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else begin
				ctl_s[k] <= src_ctl;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? diff[NUM_W-1:0] : sh[NUM_W-1:0];
			den_s[k]  <= src_den;
			quo_s[k]  <= {src_quo[QW-2:0], ge};
			data_s[k] <= src_data;
		end
	end

	assign out_ctl  = ctl_s[QW-1];
	assign out_quo  = quo_s[QW-1];
	assign out_data = data_s[QW-1];

endmodule

FILE: sv/cei_lerp.sv
// ----------------------------------------------------------------------------
// cei_lerp
// One interpolation lane: registered product of |d| and t, then
// s +/- (product >> frac) on the way out.
// ----------------------------------------------------------------------------
module cei_lerp #(
	parameter int W  = cei_pkg::TEX_WIDTH,
	parameter int TF = cei_pkg::T_FRAC_BITS
) (
	input  logic          clk,
	input  logic [W-1:0]  s,
	input  logic          neg,
	input  logic [W:0]    mag,
	input  logic [TF-1:0] t,
	output logic [W-1:0]  res
);

	logic [W+TF:0] prod_s1;
	logic [W-1:0]  s_s1;
	logic          neg_s1;
	logic [W:0]    q, sum;

	always_ff @(posedge clk) begin
		prod_s1 <= mag * t;
		s_s1    <= s;
		neg_s1  <= neg;
	end

	assign q   = prod_s1[W+TF:TF];
	assign sum = neg_s1 ? ({s_s1[W-1], s_s1} - q) : ({s_s1[W-1], s_s1} + q);
	assign res = sum[W-1:0];

endmodule

FILE: tb/tb_clip_edge_intersect_core.sv
// ----------------------------------------------------------------------------
// tb_clip_edge_intersect_core
// Self-checking bench for the edge clip intersection core. A queue of edges
// feeds a clocked driver that idles at random; a clocked monitor predicts
// each accepted beat and checks every strobed result against the oldest
// prediction. The clip boundaries are rewritten between phases, extremes
// included, and the random edges mostly straddle the selected boundary.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_clip_edge_intersect_core;

	localparam int POS_WIDTH   = cei_pkg::POS_WIDTH;
	localparam int TEX_WIDTH   = cei_pkg::TEX_WIDTH;
	localparam int T_FRAC_BITS = cei_pkg::T_FRAC_BITS;
	localparam int LATENCY     = T_FRAC_BITS + 4;

	typedef struct {
		cei_pkg::mode_t              mode;
		logic signed [POS_WIDTH-1:0] sx, sy, ex, ey;
		logic signed [TEX_WIDTH-1:0] su, sv, eu, ev;
	} seg_t;

	typedef struct {
		logic                 hit;
		logic [POS_WIDTH-1:0] x, y;
		logic [TEX_WIDTH-1:0] u, v;
	} xsect_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic                 busy;
	logic [1:0]           mode      = '0;
	logic [POS_WIDTH-1:0] start_x   = '0;
	logic [POS_WIDTH-1:0] start_y   = '0;
	logic [TEX_WIDTH-1:0] start_u   = '0;
	logic [TEX_WIDTH-1:0] start_v   = '0;
	logic [POS_WIDTH-1:0] end_x     = '0;
	logic [POS_WIDTH-1:0] end_y     = '0;
	logic [TEX_WIDTH-1:0] end_u     = '0;
	logic [TEX_WIDTH-1:0] end_v     = '0;
	logic                 done;
	logic                 hit;
	logic [POS_WIDTH-1:0] out_x;
	logic [POS_WIDTH-1:0] out_y;
	logic [TEX_WIDTH-1:0] out_u;
	logic [TEX_WIDTH-1:0] out_v;
	logic                 cfg_we    = 1'b0;
	logic [1:0]           cfg_index = '0;
	logic [POS_WIDTH-1:0] cfg_data  = '0;

	seg_t   seg_q[$];
	xsect_t xsect_q[$];
	logic signed [POS_WIDTH-1:0] bound_reg [4];
	bit     beat_taken = 1'b0;
	int     gap_pct    = 28;
	int     n_err      = 0;

	clip_edge_intersect_core dut (.*);

	always #2 clk = ~clk;

	function automatic longint bound_of(cei_pkg::mode_t m);
		case (m)
			cei_pkg::MODE_TOP:    return bound_reg[cei_pkg::REG_TOP];
			cei_pkg::MODE_BOTTOM: return bound_reg[cei_pkg::REG_BOTTOM];
			cei_pkg::MODE_LEFT:   return bound_reg[cei_pkg::REG_LEFT];
			default:              return bound_reg[cei_pkg::REG_RIGHT];
		endcase
	endfunction

	function automatic longint lerp_trunc(longint s, longint e, longint t);
		longint d, m, q;
		d = e - s;
		m = (d < 0) ? -d : d;
		q = (m * t) >>> T_FRAC_BITS;
		return (d < 0) ? s - q : s + q;
	endfunction

	function automatic xsect_t clip_seg(seg_t s);
		xsect_t r;
		bit     across_y;
		longint b, sc, ec, num, den, anum, aden, t;
		r = '{default: '0};
		across_y = (s.mode == cei_pkg::MODE_TOP) || (s.mode == cei_pkg::MODE_BOTTOM);
		b = bound_of(s.mode);
		sc = across_y ? s.sy : s.sx;
		ec = across_y ? s.ey : s.ex;
		num = b - sc;
		den = ec - sc;
		if (den == 0 || num == 0 || ((num < 0) != (den < 0)))
			return r;
		anum = (num < 0) ? -num : num;
		aden = (den < 0) ? -den : den;
		if (anum >= aden)
			return r;
		t = (anum << T_FRAC_BITS) / aden;
		r.hit = 1'b1;
		if (across_y) begin
			r.x = POS_WIDTH'(lerp_trunc(s.sx, s.ex, t));
			r.y = POS_WIDTH'(b);
		end else begin
			r.x = POS_WIDTH'(b);
			r.y = POS_WIDTH'(lerp_trunc(s.sy, s.ey, t));
		end
		r.u = TEX_WIDTH'(lerp_trunc(s.su, s.eu, t));
		r.v = TEX_WIDTH'(lerp_trunc(s.sv, s.ev, t));
		return r;
	endfunction

	// coordinate strictly on one side of b; b itself when that side is empty
	function automatic longint pick_side(longint b, bit below);
		longint span, off;
		span = below ? b + 32768 : 32767 - b;
		if (span == 0)
			return b;
		if ($urandom_range(0, 3) == 0 && span > 16)
			span = 16;
		off = $urandom_range(1, int'(span));
		return below ? b - off : b + off;
	endfunction

	function automatic seg_t rand_seg();
		seg_t   s;
		longint b, c0, c1;
		bit     below;
		int     kind;
		s.mode = cei_pkg::mode_t'($urandom_range(0, 3));
		s.sx = POS_WIDTH'($urandom);
		s.sy = POS_WIDTH'($urandom);
		s.ex = POS_WIDTH'($urandom);
		s.ey = POS_WIDTH'($urandom);
		s.su = TEX_WIDTH'($urandom);
		s.sv = TEX_WIDTH'($urandom);
		s.eu = TEX_WIDTH'($urandom);
		s.ev = TEX_WIDTH'($urandom);
		kind = $urandom_range(0, 99);
		b = bound_of(s.mode);
		below = $urandom_range(0, 1);
		if (kind < 75) begin
			c0 = pick_side(b, below);
			c1 = pick_side(b, !below);
		end else if (kind < 80) begin
			c0 = pick_side(b, below);
			c1 = c0;
		end else if (kind < 85) begin
			c0 = b;
			c1 = pick_side(b, below);
			if ($urandom_range(0, 1)) begin
				c1 = b;
				c0 = pick_side(b, below);
			end
		end else begin
			return s;
		end
		if (s.mode == cei_pkg::MODE_TOP || s.mode == cei_pkg::MODE_BOTTOM) begin
			s.sy = POS_WIDTH'(c0);
			s.ey = POS_WIDTH'(c1);
		end else begin
			s.sx = POS_WIDTH'(c0);
			s.ex = POS_WIDTH'(c1);
		end
		return s;
	endfunction

	function automatic seg_t mk(cei_pkg::mode_t m, int sx, int sy, int su, int sv,
			int ex, int ey, int eu, int ev);
		seg_t s;
		s.mode = m;
		s.sx = POS_WIDTH'(sx);
		s.sy = POS_WIDTH'(sy);
		s.su = TEX_WIDTH'(su);
		s.sv = TEX_WIDTH'(sv);
		s.ex = POS_WIDTH'(ex);
		s.ey = POS_WIDTH'(ey);
		s.eu = TEX_WIDTH'(eu);
		s.ev = TEX_WIDTH'(ev);
		return s;
	endfunction

	task automatic chk(string name, logic [TEX_WIDTH-1:0] want, logic [TEX_WIDTH-1:0] got);
		if (want !== got) begin
			n_err++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
		end
	endtask

	// driver: new beat only once the previous one was taken
	always @(negedge clk) begin
		seg_t cur;
		if (arst_n && (!start || beat_taken)) begin
			if (seg_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
				cur = seg_q.pop_front();
				start   <= 1'b1;
				mode    <= cur.mode;
				start_x <= cur.sx;
				start_y <= cur.sy;
				start_u <= cur.su;
				start_v <= cur.sv;
				end_x   <= cur.ex;
				end_y   <= cur.ey;
				end_u   <= cur.eu;
				end_v   <= cur.ev;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check strobed results, predict accepted beats, track boundaries
	always @(posedge clk) begin
		xsect_t want;
		seg_t   s;
		if (arst_n) begin
			if (done) begin
				if (xsect_q.size() == 0) begin
					n_err++;
					$display("%0t: result with nothing expected, hit %b x %h y %h u %h v %h",
						$time, hit, out_x, out_y, out_u, out_v);
				end else begin
					want = xsect_q.pop_front();
					chk("hit", want.hit, hit);
					chk("out_x", want.x, out_x);
					chk("out_y", want.y, out_y);
					chk("out_u", want.u, out_u);
					chk("out_v", want.v, out_v);
				end
			end
			beat_taken = start && !busy;
			if (beat_taken) begin
				s = mk(cei_pkg::mode_t'(mode), 0, 0, 0, 0, 0, 0, 0, 0);
				s.sx = start_x;
				s.sy = start_y;
				s.su = start_u;
				s.sv = start_v;
				s.ex = end_x;
				s.ey = end_y;
				s.eu = end_u;
				s.ev = end_v;
				xsect_q.push_back(clip_seg(s));
			end
			if (cfg_we)
				bound_reg[cfg_index] = cfg_data;
		end
	end

	task automatic drain();
		do @(posedge clk);
		while (seg_q.size() != 0 || start || xsect_q.size() != 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_bound(logic [1:0] idx, logic [POS_WIDTH-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	initial begin
		#400000;
		$display("tb_clip_edge_intersect_core: done, errors");
		$finish;
	end

	initial begin
		int ph, i;
		bound_reg[cei_pkg::REG_LEFT]   = 16'sd0;
		bound_reg[cei_pkg::REG_RIGHT]  = 16'sh7FFF;
		bound_reg[cei_pkg::REG_TOP]    = 16'sd0;
		bound_reg[cei_pkg::REG_BOTTOM] = 16'sh7FFF;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset boundaries: left 0, right max, top 0, bottom max
		seg_q.push_back(mk(cei_pkg::MODE_TOP, 0, -100, 0, 0, 320, 100, 65536, 131072));
		seg_q.push_back(mk(cei_pkg::MODE_TOP, -32768, -32768, -8388608, 8388607,
			32767, 32767, 8388607, -8388608));
		seg_q.push_back(mk(cei_pkg::MODE_TOP, 5, -1, 100, 200, -77, 32767, -300, 999));
		seg_q.push_back(mk(cei_pkg::MODE_TOP, 40, -100, 5000, -5000,
			-40, 1, -5000, 5000));
		seg_q.push_back(mk(cei_pkg::MODE_TOP, 0, 10, 1, 2, 0, 20, 3, 4));
		seg_q.push_back(mk(cei_pkg::MODE_TOP, 3, -5, 1, 2, 7, -5, 3, 4));
		seg_q.push_back(mk(cei_pkg::MODE_TOP, 1, 0, 1, 2, 9, 100, 3, 4));
		seg_q.push_back(mk(cei_pkg::MODE_TOP, 1, -100, 1, 2, 9, 0, 3, 4));
		seg_q.push_back(mk(cei_pkg::MODE_BOTTOM, 0, 0, 1, 2, 50, 32767, 3, 4));
		seg_q.push_back(mk(cei_pkg::MODE_BOTTOM, 0, 32767, 1, 2, 50, -32768, 3, 4));
		seg_q.push_back(mk(cei_pkg::MODE_BOTTOM, 10, 32000, -1, -2,
			-10, 32766, 8388607, -8388608));
		seg_q.push_back(mk(cei_pkg::MODE_LEFT, -32768, -32768, 8388607, -8388608,
			32767, 32767, -8388608, 8388607));
		seg_q.push_back(mk(cei_pkg::MODE_LEFT, 500, 7, -65536, 12345,
			-500, -7, 65536, -12345));
		seg_q.push_back(mk(cei_pkg::MODE_LEFT, -1, 100, 0, 0,
			32767, -100, 1000000, -1000000));
		seg_q.push_back(mk(cei_pkg::MODE_LEFT, 9, -3, 1, 2, 9, 40, 3, 4));
		seg_q.push_back(mk(cei_pkg::MODE_RIGHT, -32768, 1, 1, 2, 32767, 2, 3, 4));
		seg_q.push_back(mk(cei_pkg::MODE_RIGHT, 32767, 1, 1, 2, -32768, 2, 3, 4));
		seg_q.push_back(mk(cei_pkg::MODE_RIGHT, 0, 1, 1, 2, 100, 2, 3, 4));
		seg_q.push_back(mk(cei_pkg::MODE_RIGHT, 32766, -32768, -8388608, 8388607,
			32767, 32767, 8388607, -8388608));
		drain();

		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_bound(cei_pkg::REG_LEFT, 16'h8000);
					write_bound(cei_pkg::REG_RIGHT, 16'h7FFF);
					write_bound(cei_pkg::REG_TOP, 16'h8000);
					write_bound(cei_pkg::REG_BOTTOM, 16'h7FFF);
				end
				2: begin
					write_bound(cei_pkg::REG_LEFT, 16'h7FFF);
					write_bound(cei_pkg::REG_RIGHT, 16'h8000);
					write_bound(cei_pkg::REG_TOP, 16'h7FFF);
					write_bound(cei_pkg::REG_BOTTOM, 16'h8000);
				end
				4: begin
					write_bound(cei_pkg::REG_LEFT, 16'(-2560));
					write_bound(cei_pkg::REG_RIGHT, 16'(2560));
					write_bound(cei_pkg::REG_TOP, 16'(-1920));
					write_bound(cei_pkg::REG_BOTTOM, 16'(1920));
				end
				default: begin
					write_bound(cei_pkg::REG_LEFT, 16'($urandom));
					write_bound(cei_pkg::REG_RIGHT, 16'($urandom));
					write_bound(cei_pkg::REG_TOP, 16'($urandom));
					write_bound(cei_pkg::REG_BOTTOM, 16'($urandom));
				end
			endcase
			gap_pct = (ph < 2) ? 28 : (ph < 4) ? 49 : 0;
			for (i = 0; i < 160; i++) begin
				// sender holds off until the pipe is empty
				if (ph == 3 && i == 80)
					drain();
				seg_q.push_back(rand_seg());
			end
			drain();
		end

		repeat (2 * LATENCY) @(posedge clk);
		if (xsect_q.size() != 0) begin
			n_err++;
			$display("%0t: %0d results never arrived", $time, xsect_q.size());
		end
		if (n_err == 0)
			$display("tb_clip_edge_intersect_core: done, clean");
		else
			$display("tb_clip_edge_intersect_core: done, errors");
		$finish;
	end

endmodule
